// ----- rtl/wbg_pkg.sv -----
// Shared types, constants and helpers for the world boundary geometry block.
package wbg_pkg;

	// fixed point format of all coordinates and lengths
	localparam int FRAC_BITS = 16;
	localparam logic [30:0] ONE_FX = 31'(64'd1 << FRAC_BITS);
	localparam logic [30:0] RADIUS_MIN = 31'(64'd10 << FRAC_BITS);

	// square root unit: 66-bit radicand, 33-bit root
	localparam int SQ_ROOT_W = 33;
	localparam int SQ_RAD_W = 2 * SQ_ROOT_W;

	// divider unit: 63-bit dividend, 33-bit divisor, 31-bit quotient
	localparam int DIV_DVD_W = 63;
	localparam int DIV_DVS_W = 33;
	localparam int DIV_QUO_W = 31;

	typedef enum logic [1:0] {
		FUNC_INSIDE = 2'd0,
		FUNC_CLAMP  = 2'd1,
		FUNC_WRAP   = 2'd2,
		FUNC_DIST   = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		REG_SHAPE  = 3'd0,
		REG_WIDTH  = 3'd1,
		REG_HEIGHT = 3'd2,
		REG_RADIUS = 3'd3,
		REG_CX     = 3'd4,
		REG_CY     = 3'd5
	} reg_idx_t;

	typedef struct packed {
		func_t              func;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic        [30:0] r;
	} wbg_item_t;

	typedef struct packed {
		wbg_item_t             item;
		logic [SQ_ROOT_W-1:0]  len;
		logic                  keep;
		logic                  sx;
		logic                  sy;
	} wbg_div_side_t;

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [31:0] res;
		if (v > 36'sh0_7FFF_FFFF)
			res = 32'sh7FFF_FFFF;
		else if (v < -36'sh0_8000_0000)
			res = 32'sh8000_0000;
		else
			res = v[31:0];
		return res;
	endfunction

endpackage

// ----- rtl/wbg_isqrt.sv -----
// Pipelined integer square root, one root bit per stage.
module wbg_isqrt #(
	parameter int SIDE_W = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [wbg_pkg::SQ_RAD_W-1:0]  in_rad,
	input  logic [SIDE_W-1:0]             in_side,
	output logic                          out_valid,
	output logic [wbg_pkg::SQ_ROOT_W-1:0] out_root,
	output logic [SIDE_W-1:0]             out_side
);

	localparam int N = wbg_pkg::SQ_ROOT_W;
	localparam int RAD_W = wbg_pkg::SQ_RAD_W;
	localparam int REM_W = N + 2;

	logic             vld_s  [N+1];
	logic [RAD_W-1:0] rad_s  [N+1];
	logic [REM_W-1:0] rem_s  [N+1];
	logic [N-1:0]     root_s [N+1];
	logic [SIDE_W-1:0] side_s [N+1];

	assign vld_s[0]  = in_valid;
	assign rad_s[0]  = in_rad;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < N; k++) begin : g_stage
		localparam int I = N - 1 - k;
		logic [REM_W+1:0] rt;
		logic [REM_W+1:0] tr;
		logic [REM_W+1:0] df;
		logic             ge;

		always_comb begin
			rt = {rem_s[k], rad_s[k][2*I +: 2]};
			tr = (REM_W+2)'({root_s[k], 2'b01});
			ge = (rt >= tr);
			df = rt - tr;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else if (en)
				vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1]  <= rad_s[k];
				side_s[k+1] <= side_s[k];
				rem_s[k+1]  <= ge ? df[REM_W-1:0] : rt[REM_W-1:0];
				root_s[k+1] <= {root_s[k][N-2:0], ge};
			end
		end
	end

	assign out_valid = vld_s[N];
	assign out_root  = root_s[N];
	assign out_side  = side_s[N];

endmodule

// ----- rtl/wbg_div2.sv -----
// Two-lane pipelined restoring divider, one quotient bit per stage.
module wbg_div2 #(
	parameter int SIDE_W = 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic [1:0][wbg_pkg::DIV_DVD_W-1:0]  in_dvd,
	input  logic [1:0][wbg_pkg::DIV_DVS_W-1:0]  in_dvs,
	input  logic [SIDE_W-1:0]                   in_side,
	output logic                                out_valid,
	output logic [1:0][wbg_pkg::DIV_QUO_W-1:0]  out_quo,
	output logic [1:0][wbg_pkg::DIV_DVS_W-1:0]  out_rem,
	output logic [SIDE_W-1:0]                   out_side
);

	localparam int DW = wbg_pkg::DIV_DVD_W;
	localparam int SW = wbg_pkg::DIV_DVS_W;
	localparam int Q  = wbg_pkg::DIV_QUO_W;

	logic                vld_s  [Q+1];
	logic [1:0][DW-1:0]  dvd_s  [Q+1];
	logic [1:0][SW-1:0]  dvs_s  [Q+1];
	logic [1:0][SW-1:0]  rem_s  [Q+1];
	logic [1:0][Q-1:0]   quo_s  [Q+1];
	logic [SIDE_W-1:0]   side_s [Q+1];

	assign vld_s[0]    = in_valid;
	assign dvd_s[0]    = in_dvd;
	assign dvs_s[0]    = in_dvs;
	assign rem_s[0][0] = SW'(in_dvd[0][DW-1:Q]);
	assign rem_s[0][1] = SW'(in_dvd[1][DW-1:Q]);
	assign quo_s[0]    = '0;
	assign side_s[0]   = in_side;

	for (genvar k = 0; k < Q; k++) begin : g_stage
		localparam int J = Q - 1 - k;
		logic [1:0][SW:0]   sh;
		logic [1:0][SW:0]   df;
		logic [1:0]         ge;
		logic [1:0][SW-1:0] rem_nx;

		always_comb begin
			for (int l = 0; l < 2; l++) begin
				sh[l]     = {rem_s[k][l], dvd_s[k][l][J]};
				ge[l]     = (sh[l] >= {1'b0, dvs_s[k][l]});
				df[l]     = sh[l] - {1'b0, dvs_s[k][l]};
				rem_nx[l] = ge[l] ? df[l][SW-1:0] : sh[l][SW-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else if (en)
				vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dvd_s[k+1]     <= dvd_s[k];
				dvs_s[k+1]     <= dvs_s[k];
				side_s[k+1]    <= side_s[k];
				rem_s[k+1]     <= rem_nx;
				quo_s[k+1][0]  <= {quo_s[k][0][Q-2:0], ge[0]};
				quo_s[k+1][1]  <= {quo_s[k][1][Q-2:0], ge[1]};
			end
		end
	end

	assign out_valid = vld_s[Q];
	assign out_quo   = quo_s[Q];
	assign out_rem   = rem_s[Q];
	assign out_side  = side_s[Q];

endmodule

// ----- rtl/world_boundary_geometry_top.sv -----
// Top level of the world boundary geometry block: config, pipeline and output skid.
//
// Answers one boundary query per input word against a rectangular or circular
// world held in configuration registers. All values are signed Q15.16.
//   s_* channel : query word; tuser = func, tdata = pos_x, pos_y, body_radius.
//   m_* channel : result word; tdata = inside_flag, out_x, out_y, wall_distance.
//   cfg_*       : register write; cfg_index selects the register, cfg_data the
//                 value. Always ready. Write only while no query is in flight.
// Pipeline: the path holds 74 register stages, namely a 33-stage square root
// (distance to the center or to the clamped point), a 31-stage divider (radial
// scaling, modulo wrap), nine stages of setup, multiply and result muxing, and
// the output register.
// Throughput: one query per cycle while the skid is empty; while it is full,
// s_tready is low and the pipeline holds.
// Reset: config returns to rectangle 1.0 x 1.0, radius 10.0, center (0,0);
// the pipeline empties, m_tvalid drops.
// Stall: a two-word output buffer (output register plus skid) sits behind the
// pipeline. When m_tready is low the skid fills, then s_tready drops and the
// whole pipeline holds; nothing is lost or repeated.
module world_boundary_geometry_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,   // pos_x[31:0], pos_y[63:32], body_radius[95:64]
	input  logic [1:0]   s_tuser,   // func[1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,   // inside_flag[0], out_x[32:1], out_y[64:33],
	                                // wall_distance[96:65], zero[103:97]
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int ITEM_W = $bits(wbg_pkg::wbg_item_t);
	localparam int DSIDE_W = $bits(wbg_pkg::wbg_div_side_t);

	// ---------------- configuration registers ----------------
	logic               shape_q;
	logic        [30:0] width_q;
	logic        [30:0] height_q;
	logic        [30:0] radius_q;
	logic signed [31:0] cx_q;
	logic signed [31:0] cy_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_q  <= 1'b0;
			width_q  <= wbg_pkg::ONE_FX;
			height_q <= wbg_pkg::ONE_FX;
			radius_q <= wbg_pkg::RADIUS_MIN;
			cx_q     <= '0;
			cy_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				wbg_pkg::REG_SHAPE:  shape_q <= cfg_data[0];
				wbg_pkg::REG_WIDTH:  width_q <= (cfg_data[30:0] < wbg_pkg::ONE_FX) ?
					wbg_pkg::ONE_FX : cfg_data[30:0];
				wbg_pkg::REG_HEIGHT: height_q <= (cfg_data[30:0] < wbg_pkg::ONE_FX) ?
					wbg_pkg::ONE_FX : cfg_data[30:0];
				wbg_pkg::REG_RADIUS: radius_q <= (cfg_data[30:0] < wbg_pkg::RADIUS_MIN) ?
					wbg_pkg::RADIUS_MIN : cfg_data[30:0];
				wbg_pkg::REG_CX:     cx_q <= cfg_data;
				wbg_pkg::REG_CY:     cy_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- pipeline advance ----------------
	// every stage moves together; only a full skid holds the pipe
	logic skid_full_q;
	logic adv;
	assign adv      = !skid_full_q;
	assign s_tready = adv;

	// zero-extended geometry constants
	logic signed [32:0] w33, h33;
	assign w33 = {2'b00, width_q};
	assign h33 = {2'b00, height_q};

	// ---------------- S1: capture query ----------------
	wbg_pkg::wbg_item_t it_in, it_s1;
	logic v_s1;

	always_comb begin
		it_in.func = wbg_pkg::func_t'(s_tuser);
		it_in.x    = s_tdata[31:0];
		it_in.y    = s_tdata[63:32];
		it_in.r    = s_tdata[95] ? 31'd0 : s_tdata[94:64];   // negative radius -> 0
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv)
			v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (adv)
			it_s1 <= it_in;
	end

	// ---------------- S2: rect clamp (r = 0), center offsets ----------------
	wbg_pkg::wbg_item_t it_s2;
	logic               v_s2;
	logic        [30:0] clx_s2, cly_s2;
	logic signed [32:0] cdx_s2, cdy_s2;
	logic signed [32:0] x1e, y1e, mnx1, mny1;

	always_comb begin
		x1e  = {it_s1.x[31], it_s1.x};
		y1e  = {it_s1.y[31], it_s1.y};
		mnx1 = (x1e < w33) ? x1e : w33;
		mny1 = (y1e < h33) ? y1e : h33;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (adv)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s2  <= it_s1;
			clx_s2 <= mnx1[32] ? 31'd0 : mnx1[30:0];
			cly_s2 <= mny1[32] ? 31'd0 : mny1[30:0];
			cdx_s2 <= x1e - {cx_q[31], cx_q};
			cdy_s2 <= y1e - {cy_q[31], cy_q};
		end
	end

	// ---------------- S3: vector to measure, magnitudes ----------------
	wbg_pkg::wbg_item_t it_s3;
	logic               v_s3;
	logic        [31:0] ax_s3, ay_s3;
	logic signed [32:0] dx2, dy2, ndx2, ndy2;

	always_comb begin
		dx2  = shape_q ? cdx_s2 : ({it_s2.x[31], it_s2.x} - {2'b00, clx_s2});
		dy2  = shape_q ? cdy_s2 : ({it_s2.y[31], it_s2.y} - {2'b00, cly_s2});
		ndx2 = -dx2;
		ndy2 = -dy2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (adv)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s3 <= it_s2;
			ax_s3 <= dx2[32] ? ndx2[31:0] : dx2[31:0];
			ay_s3 <= dy2[32] ? ndy2[31:0] : dy2[31:0];
		end
	end

	// ---------------- S4: squares ----------------
	wbg_pkg::wbg_item_t it_s4;
	logic               v_s4;
	logic [63:0]        sqx_s4, sqy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (adv)
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s4  <= it_s3;
			sqx_s4 <= ax_s3 * ax_s3;
			sqy_s4 <= ay_s3 * ay_s3;
		end
	end

	// ---------------- S5: sum of squares ----------------
	wbg_pkg::wbg_item_t              it_s5;
	logic                            v_s5;
	logic [wbg_pkg::SQ_RAD_W-1:0]    rad_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s5 <= 1'b0;
		else if (adv)
			v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s5  <= it_s4;
			rad_s5 <= {2'b00, sqx_s4} + {2'b00, sqy_s4};
		end
	end

	// ---------------- square root ----------------
	logic                           sq_valid;
	logic [wbg_pkg::SQ_ROOT_W-1:0]  sq_len;
	logic [ITEM_W-1:0]              sq_side;
	wbg_pkg::wbg_item_t             sq_item;

	wbg_isqrt #(
		.SIDE_W (ITEM_W)
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s5),
		.in_rad    (rad_s5),
		.in_side   (it_s5),
		.out_valid (sq_valid),
		.out_root  (sq_len),
		.out_side  (sq_side)
	);

	assign sq_item = sq_side;

	// ---------------- S6: radial limit, keep test, center offsets ----------------
	wbg_pkg::wbg_item_t  it_s6;
	logic                v_s6;
	logic [32:0]         len_s6;
	logic [30:0]         maxd_s6;
	logic                keep_s6;
	logic [31:0]         ax_s6, ay_s6;
	logic                sx_s6, sy_s6;
	logic [30:0]         rr6;
	logic signed [32:0]  diff6, cdx6, cdy6, ncdx6, ncdy6;
	logic [30:0]         maxd6;

	always_comb begin
		rr6   = (sq_item.func == wbg_pkg::FUNC_CLAMP) ? sq_item.r : 31'd0;
		diff6 = {2'b00, radius_q} - {2'b00, rr6};
		maxd6 = (diff6 < 33'sd1) ? 31'd1 : diff6[30:0];
		cdx6  = {sq_item.x[31], sq_item.x} - {cx_q[31], cx_q};
		cdy6  = {sq_item.y[31], sq_item.y} - {cy_q[31], cy_q};
		ncdx6 = -cdx6;
		ncdy6 = -cdy6;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s6 <= 1'b0;
		else if (adv)
			v_s6 <= sq_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s6   <= sq_item;
			len_s6  <= sq_len;
			maxd_s6 <= maxd6;
			keep_s6 <= (sq_len <= {2'b00, maxd6}) || (sq_len <= 33'd1);
			ax_s6   <= cdx6[32] ? ncdx6[31:0] : cdx6[31:0];
			ay_s6   <= cdy6[32] ? ncdy6[31:0] : cdy6[31:0];
			sx_s6   <= cdx6[32];
			sy_s6   <= cdy6[32];
		end
	end

	// ---------------- S7: scaled offsets / wrap operands ----------------
	logic                                v_s7;
	logic [1:0][wbg_pkg::DIV_DVD_W-1:0]  dvd_s7;
	logic [1:0][wbg_pkg::DIV_DVS_W-1:0]  dvs_s7;
	wbg_pkg::wbg_div_side_t              side_s7;
	logic [62:0]                         px7, py7;
	logic [31:0]                         ux7, uy7;

	always_comb begin
		px7 = ax_s6 * maxd_s6;
		py7 = ay_s6 * maxd_s6;
		ux7 = it_s6.x[31] ? (~it_s6.x + 32'd1) : it_s6.x;
		uy7 = it_s6.y[31] ? (~it_s6.y + 32'd1) : it_s6.y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s7 <= 1'b0;
		else if (adv)
			v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dvd_s7[0]    <= shape_q ? px7 : {31'd0, ux7};
			dvd_s7[1]    <= shape_q ? py7 : {31'd0, uy7};
			dvs_s7[0]    <= shape_q ? len_s6 : {2'b00, width_q};
			dvs_s7[1]    <= shape_q ? len_s6 : {2'b00, height_q};
			side_s7.item <= it_s6;
			side_s7.len  <= len_s6;
			side_s7.keep <= keep_s6;
			side_s7.sx   <= sx_s6;
			side_s7.sy   <= sy_s6;
		end
	end

	// ---------------- divider ----------------
	logic                                dv_valid;
	logic [1:0][wbg_pkg::DIV_QUO_W-1:0]  dv_quo;
	logic [1:0][wbg_pkg::DIV_DVS_W-1:0]  dv_rem;
	logic [DSIDE_W-1:0]                  dv_side_raw;
	wbg_pkg::wbg_div_side_t              dv_side;

	wbg_div2 #(
		.SIDE_W (DSIDE_W)
	) u_div2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s7),
		.in_dvd    (dvd_s7),
		.in_dvs    (dvs_s7),
		.in_side   (side_s7),
		.out_valid (dv_valid),
		.out_quo   (dv_quo),
		.out_rem   (dv_rem),
		.out_side  (dv_side_raw)
	);

	assign dv_side = dv_side_raw;

	// ---------------- S8: per-function results, before saturation ----------------
	logic               v_s8;
	logic               flag_s8;
	logic signed [33:0] ox_s8, oy_s8;
	logic signed [34:0] dist_s8;

	wbg_pkg::wbg_item_t it8;
	logic signed [32:0] x8, y8, r8, wr8, hr8, mnx8, mny8, rcx8, rcy8;
	logic signed [32:0] dxw8, dyh8, ma8, mb8, mab8;
	logic signed [33:0] cx8, cy8, qx8, qy8, ccx8, ccy8;
	logic signed [34:0] rmr8, len8, dist8;
	logic [30:0]        remx8, remy8, wx8, wy8;
	logic               flag8, in0_8;
	logic signed [33:0] ox8, oy8;

	always_comb begin
		it8  = dv_side.item;
		x8   = {it8.x[31], it8.x};
		y8   = {it8.y[31], it8.y};
		r8   = {2'b00, it8.r};
		wr8  = w33 - r8;
		hr8  = h33 - r8;
		len8 = {2'b00, dv_side.len};
		rmr8 = {4'b0000, radius_q} - {4'b0000, it8.r};

		// rectangle clamp: lower bound wins when the span is inverted
		mnx8 = (x8 < wr8) ? x8 : wr8;
		mny8 = (y8 < hr8) ? y8 : hr8;
		rcx8 = (mnx8 < r8) ? r8 : mnx8;
		rcy8 = (mny8 < r8) ? r8 : mny8;

		// circle clamp: center plus signed scaled offset, or the point itself
		cx8  = {{2{cx_q[31]}}, cx_q};
		cy8  = {{2{cy_q[31]}}, cy_q};
		qx8  = {3'b000, dv_quo[0]};
		qy8  = {3'b000, dv_quo[1]};
		ccx8 = dv_side.keep ? {it8.x[31], x8} : (dv_side.sx ? cx8 - qx8 : cx8 + qx8);
		ccy8 = dv_side.keep ? {it8.y[31], y8} : (dv_side.sy ? cy8 - qy8 : cy8 + qy8);

		// floor modulo from the magnitude remainder
		remx8 = dv_rem[0][30:0];
		remy8 = dv_rem[1][30:0];
		wx8   = (it8.x[31] && (remx8 != 31'd0)) ? width_q - remx8 : remx8;
		wy8   = (it8.y[31] && (remy8 != 31'd0)) ? height_q - remy8 : remy8;

		// rectangle inside distance
		in0_8 = !x8[32] && !y8[32] && (x8 <= w33) && (y8 <= h33);
		dxw8  = w33 - x8;
		dyh8  = h33 - y8;
		ma8   = (x8 < dxw8) ? x8 : dxw8;
		mb8   = (y8 < dyh8) ? y8 : dyh8;
		mab8  = (ma8 < mb8) ? ma8 : mb8;

		flag8 = 1'b0;
		ox8   = '0;
		oy8   = '0;
		dist8 = '0;
		case (it8.func)
			wbg_pkg::FUNC_INSIDE: begin
				if (shape_q)
					flag8 = (len8 <= rmr8);
				else
					flag8 = (x8 >= r8) && (y8 >= r8) && (x8 <= wr8) && (y8 <= hr8);
			end
			wbg_pkg::FUNC_CLAMP: begin
				ox8 = shape_q ? ccx8 : {rcx8[32], rcx8};
				oy8 = shape_q ? ccy8 : {rcy8[32], rcy8};
			end
			wbg_pkg::FUNC_WRAP: begin
				ox8 = shape_q ? ccx8 : {3'b000, wx8};
				oy8 = shape_q ? ccy8 : {3'b000, wy8};
			end
			wbg_pkg::FUNC_DIST: begin
				if (shape_q)
					dist8 = {4'b0000, radius_q} - len8;
				else if (in0_8)
					dist8 = {{2{mab8[32]}}, mab8};
				else
					dist8 = -len8;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s8 <= 1'b0;
		else if (adv)
			v_s8 <= dv_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flag_s8 <= flag8;
			ox_s8   <= ox8;
			oy_s8   <= oy8;
			dist_s8 <= dist8;
		end
	end

	// ---------------- S9: saturate and pack ----------------
	logic         v_s9;
	logic [103:0] word_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s9 <= 1'b0;
		else if (adv)
			v_s9 <= v_s8;
	end

	always_ff @(posedge clk) begin
		if (adv)
			word_s9 <= {7'd0,
			            wbg_pkg::sat32({dist_s8[34], dist_s8}),
			            wbg_pkg::sat32({{2{oy_s8[33]}}, oy_s8}),
			            wbg_pkg::sat32({{2{ox_s8[33]}}, ox_s8}),
			            flag_s8};
	end

	// ---------------- output register and skid ----------------
	logic         out_valid_q;
	logic [103:0] out_q;
	logic [103:0] skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (m_tready)
				skid_full_q <= 1'b0;
		end else if (v_s9) begin
			if (out_valid_q && !m_tready)
				skid_full_q <= 1'b1;
			else
				out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_full_q) begin
			if (m_tready)
				out_q <= skid_q;
		end else if (v_s9) begin
			if (out_valid_q && !m_tready)
				skid_q <= word_s9;
			else
				out_q <= word_s9;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	// ---------------- assertions ----------------
	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q |-> out_valid_q)
		else $error("skid holds a word while the output register is empty");

	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_full_q) |-> $past(out_valid_q && !m_tready && v_s9))
		else $error("skid filled without a stalled output");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s7 && shape_q && !side_s7.keep &&
		 (side_s7.item.func == wbg_pkg::FUNC_CLAMP || side_s7.item.func == wbg_pkg::FUNC_WRAP))
		|-> (dvs_s7[0] >= 33'd2))
		else $error("radial scaling divides by a length below two");

endmodule
